@@ src/ssr_pkg.sv @@
`timescale 1ns / 1ps
package ssr_pkg;

   localparam int MAX_COPIES   = 64;
   localparam int COPY_W       = $clog2(MAX_COPIES);
   localparam int COUNT_W      = 7;
   localparam int ADDR_W       = 32;
   localparam int PORT_W       = 16;
   localparam int EGRESS_W     = 8;
   localparam int KIND_W       = 2;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int REQ_DATA_W   = 64;
   localparam int REQ_USER_W   = 3;
   localparam int RSP_DATA_W   = 40;

   localparam logic [PORT_W-1:0] PORT_MAX = {PORT_W{1'b1}};

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SUBNET_ADDR     = 3'd0,
      CSR_SUBNET_MASK     = 3'd1,
      CSR_INTERNAL_EGRESS = 3'd2,
      CSR_EXTERNAL_EGRESS = 3'd3,
      CSR_COPY_COUNT      = 3'd4
   } csr_index_type;

   typedef enum logic [KIND_W-1:0] {
      L4_OTHER = 2'd0,
      L4_UDP   = 2'd1,
      L4_TCP   = 2'd2
   } l4_kind_type;

   typedef enum logic [1:0] {
      RW_NONE = 2'b00,
      RW_SRC  = 2'b01,
      RW_DST  = 2'b10
   } rewrite_type;

   typedef struct packed {
      logic                is_ipv4;
      logic [KIND_W-1:0]   l4_kind;
      logic [ADDR_W-1:0]   source_address;
      logic [PORT_W-1:0]   source_l4_port;
      logic [PORT_W-1:0]   dest_l4_port;
   } req_item_type;

   typedef struct packed {
      logic [EGRESS_W-1:0] egress;
      logic [PORT_W-1:0]   source_l4_port;
      logic [PORT_W-1:0]   dest_l4_port;
      rewrite_type         rewrite;
      logic [COPY_W-1:0]   copies_left;
   } steer_item_type;

   function automatic logic [PORT_W-1:0] advance_port(input logic [PORT_W-1:0] v);
      logic [PORT_W-1:0] r;
      if (v == PORT_MAX) begin
         r = {{(PORT_W-1){1'b0}}, 1'b1};
      end else begin
         r = v + {{(PORT_W-1){1'b0}}, 1'b1};
      end
      return r;
   endfunction

endpackage

@@ src/subnet_steer_and_replicate.sv @@
`timescale 1ns / 1ps
// Steers parsed headers to an internal or external egress and emits copy_count
// copies of each (0 as 1, max 64), the rewritten L4 port stepping one per copy.
// req_ channel: one header summary per item; rsp_ channel: one copy per item,
// rsp_tlast marks the final copy of a packet.
// csr_ port: write csr_wdata into register csr_index when csr_wen is high;
// write only while no packet is in flight.
// The first copy of a packet passes the input stage, the steering stage and
// the copy output register before it is valid on rsp_.
// The input side takes one item per cycle while rsp_tready is high and
// copy_count is 0 or 1; otherwise the copy output register emits one copy
// per cycle while rsp_tready is high and takes no new item until the last copy.
// Reset clears all valid bits and loads register defaults: subnet 0, mask 0,
// internal egress 1, external egress 2, copy count 1.
// When rsp_tready is low the current copy holds and the stages behind it fill
// and then drop req_tready; nothing is lost or repeated.
module subnet_steer_and_replicate (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [31:0] source_address, [47:32] source_l4_port, [63:48] dest_l4_port
   input  logic [ssr_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [0] is_ipv4, [2:1] l4_kind
   input  logic [ssr_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] egress, [23:8] out_source_l4_port, [39:24] out_dest_l4_port
   output logic [ssr_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tlast,
   input  logic                              csr_wen,
   input  logic [ssr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ssr_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ssr_pkg::*;

   logic [ADDR_W-1:0]   subnet_addr_ff;
   logic [ADDR_W-1:0]   subnet_mask_ff;
   logic [EGRESS_W-1:0] internal_egress_ff;
   logic [EGRESS_W-1:0] external_egress_ff;
   logic [COUNT_W-1:0]  copy_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         subnet_addr_ff     <= '0;
         subnet_mask_ff     <= '0;
         internal_egress_ff <= EGRESS_W'(1);
         external_egress_ff <= EGRESS_W'(2);
         copy_count_ff      <= COUNT_W'(1);
      end else if (csr_wen) begin
         unique case (csr_index_type'(csr_index))
            CSR_SUBNET_ADDR:     subnet_addr_ff     <= csr_wdata[ADDR_W-1:0];
            CSR_SUBNET_MASK:     subnet_mask_ff     <= csr_wdata[ADDR_W-1:0];
            CSR_INTERNAL_EGRESS: internal_egress_ff <= csr_wdata[EGRESS_W-1:0];
            CSR_EXTERNAL_EGRESS: external_egress_ff <= csr_wdata[EGRESS_W-1:0];
            CSR_COPY_COUNT:      copy_count_ff      <= csr_wdata[COUNT_W-1:0];
            default:             copy_count_ff      <= copy_count_ff;
         endcase
      end
   end

   logic           s1_valid_ff;
   req_item_type   s1_item_ff, s1_item_in;
   logic           s1_ready;
   logic           s2_valid_ff;
   steer_item_type s2_item_ff, s2_item_in;
   logic           s2_ready;
   logic           rep_ready;

   assign s2_ready   = !s2_valid_ff || rep_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;

   always_comb begin
      s1_item_in.is_ipv4        = req_tuser[0];
      s1_item_in.l4_kind        = req_tuser[2:1];
      s1_item_in.source_address = req_tdata[31:0];
      s1_item_in.source_l4_port = req_tdata[47:32];
      s1_item_in.dest_l4_port   = req_tdata[63:48];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_tvalid;
      end
      if (s1_ready) begin
         s1_item_ff <= s1_item_in;
      end
   end

   logic in_subnet;
   logic l4_ok;
   logic steer;

   always_comb begin
      in_subnet = ((s1_item_ff.source_address ^ subnet_addr_ff) & subnet_mask_ff) == '0;
      l4_ok  = (l4_kind_type'(s1_item_ff.l4_kind) == L4_UDP) ||
               (l4_kind_type'(s1_item_ff.l4_kind) == L4_TCP);
      steer  = s1_item_ff.is_ipv4 && l4_ok;

      s2_item_in.egress         = external_egress_ff;
      s2_item_in.rewrite        = RW_NONE;
      s2_item_in.source_l4_port = s1_item_ff.source_l4_port;
      s2_item_in.dest_l4_port   = s1_item_ff.dest_l4_port;
      if (steer && in_subnet) begin
         s2_item_in.egress         = internal_egress_ff;
         s2_item_in.rewrite        = RW_SRC;
         s2_item_in.source_l4_port = advance_port(s1_item_ff.source_l4_port);
      end else if (steer) begin
         s2_item_in.rewrite        = RW_DST;
         s2_item_in.dest_l4_port   = advance_port(s1_item_ff.dest_l4_port);
      end

      if (copy_count_ff == '0) begin
         s2_item_in.copies_left = '0;
      end else if (copy_count_ff >= COUNT_W'(MAX_COPIES)) begin
         s2_item_in.copies_left = COPY_W'(MAX_COPIES - 1);
      end else begin
         s2_item_in.copies_left = COPY_W'(copy_count_ff - COUNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s2_ready) begin
         s2_item_ff <= s2_item_in;
      end
   end

   ssr_replicator u_replicator (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid_ff),
      .in_ready  (rep_ready),
      .in_item   (s2_item_ff),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

endmodule

@@ src/ssr_replicator.sv @@
`timescale 1ns / 1ps
module ssr_replicator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  ssr_pkg::steer_item_type         in_item,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [ssr_pkg::RSP_DATA_W-1:0]  out_data,
   output logic                            out_last
);
   import ssr_pkg::*;

   logic                 valid_ff, valid_in;
   steer_item_type       item_ff, item_in;
   logic                 take;
   logic                 is_last;
   logic                 load;

   assign is_last  = (item_ff.copies_left == '0);
   assign take     = valid_ff && out_ready;
   assign in_ready = !valid_ff || (out_ready && is_last);
   assign load     = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in = 1'b1;
         item_in  = in_item;
      end else if (take) begin
         if (is_last) begin
            valid_in = 1'b0;
         end else begin
            item_in.copies_left = item_ff.copies_left - {{(COPY_W-1){1'b0}}, 1'b1};
            unique case (item_ff.rewrite)
               RW_SRC:  item_in.source_l4_port = advance_port(item_ff.source_l4_port);
               RW_DST:  item_in.dest_l4_port   = advance_port(item_ff.dest_l4_port);
               RW_NONE: item_in.egress         = item_ff.egress;
               default: item_in.egress         = item_ff.egress;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_last  = is_last;
   assign out_data  = {item_ff.dest_l4_port, item_ff.source_l4_port, item_ff.egress};

endmodule

@@ tb/tb_subnet_steer_and_replicate.sv @@
`timescale 1ns / 1ps
module tb_subnet_steer_and_replicate;
   import ssr_pkg::*;

   localparam int                RESET_CYCLES   = 12;
   localparam int                LONG_HOLD      = 260;
   localparam int                WATCHDOG_LIMIT = 4000;
   localparam int                DRAIN_CYCLES   = 10;
   localparam int                RANDOM_PHASES  = 7;
   localparam int                PHASE_ITEMS    = 30;
   localparam logic [KIND_W-1:0] L4_RESERVED    = 2'd3;
   localparam int                CSR_SPARE_LO   = int'(CSR_COPY_COUNT) + 1;
   localparam int                CSR_SPARE_HI   = (1 << CSR_INDEX_W) - 1;

   typedef struct packed {
      logic [EGRESS_W-1:0] egress;
      logic [PORT_W-1:0]   out_source_l4_port;
      logic [PORT_W-1:0]   out_dest_l4_port;
      logic                last_copy;
   } steer_copy_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic [REQ_USER_W-1:0]  req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_wen    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   logic [ADDR_W-1:0]      cfg_subnet_addr = '0;
   logic [ADDR_W-1:0]      cfg_subnet_mask = '0;
   logic [EGRESS_W-1:0]    cfg_internal    = 8'd1;
   logic [EGRESS_W-1:0]    cfg_external    = 8'd2;
   logic [COUNT_W-1:0]     cfg_copy_count  = 7'd1;

   req_item_type           pending_headers[$];
   steer_copy_type         copies_expected[$];
   int                     queued_headers   = 0;
   int                     accepted_headers = 0;
   int                     copies_checked   = 0;
   int                     mismatches       = 0;
   int                     setups_applied   = 0;
   int                     send_gap         = 0;
   int                     sink_gap         = 0;
   int                     long_hold        = 0;
   int                     quiet_cycles     = 0;
   logic                   calm             = 1'b0;
   logic                   stall_request    = 1'b0;
   logic                   stall_done       = 1'b0;

   subnet_steer_and_replicate i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [PORT_W-1:0] bump_port(input logic [PORT_W-1:0] p);
      return (p == {PORT_W{1'b1}}) ? 16'd1 : p + 16'd1;
   endfunction

   function automatic void forecast_copies(input req_item_type hdr);
      int                  n;
      logic [EGRESS_W-1:0] eg;
      rewrite_type         rw;
      logic [PORT_W-1:0]   sp;
      logic [PORT_W-1:0]   dp;
      logic                in_subnet;
      steer_copy_type      c;
      n = (cfg_copy_count == 0) ? 1 :
          (cfg_copy_count > MAX_COPIES) ? MAX_COPIES : int'(cfg_copy_count);
      eg = cfg_external;
      rw = RW_NONE;
      sp = hdr.source_l4_port;
      dp = hdr.dest_l4_port;
      in_subnet = (((hdr.source_address ^ cfg_subnet_addr) & cfg_subnet_mask) == '0);
      if (hdr.is_ipv4 && (hdr.l4_kind == L4_UDP || hdr.l4_kind == L4_TCP)) begin
         if (in_subnet) begin
            eg = cfg_internal;
            rw = RW_SRC;
         end else begin
            rw = RW_DST;
         end
      end
      for (int k = 0; k < n; k++) begin
         if (rw == RW_SRC) begin
            sp = bump_port(sp);
         end else if (rw == RW_DST) begin
            dp = bump_port(dp);
         end
         c.egress             = eg;
         c.out_source_l4_port = sp;
         c.out_dest_l4_port   = dp;
         c.last_copy          = (k == n - 1);
         copies_expected.push_back(c);
      end
   endfunction

   always @(posedge clock) begin
      req_item_type hdr;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap   <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap > 0) begin
            send_gap   <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_headers.size() != 0) begin
            hdr = pending_headers.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {hdr.dest_l4_port, hdr.source_l4_port, hdr.source_address};
            req_tuser  <= {hdr.l4_kind, hdr.is_ipv4};
            if (!calm && $urandom_range(0, 7) == 0) begin
               send_gap <= $urandom_range(1, 18);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         sink_gap   <= 0;
         long_hold  <= 0;
      end else if (long_hold > 0) begin
         long_hold  <= long_hold - 1;
         rsp_tready <= 1'b0;
      end else if (stall_request && !stall_done) begin
         stall_done <= 1'b1;
         long_hold  <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (sink_gap > 0) begin
         sink_gap   <= sink_gap - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!calm && $urandom_range(0, 9) == 0) begin
            sink_gap <= $urandom_range(1, 18);
         end
      end
   end

   always @(posedge clock) begin
      req_item_type   hdr;
      steer_copy_type seen;
      steer_copy_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            hdr.is_ipv4        = req_tuser[0];
            hdr.l4_kind        = req_tuser[KIND_W:1];
            hdr.source_address = req_tdata[ADDR_W-1:0];
            hdr.source_l4_port = req_tdata[ADDR_W +: PORT_W];
            hdr.dest_l4_port   = req_tdata[ADDR_W + PORT_W +: PORT_W];
            forecast_copies(hdr);
            accepted_headers++;
         end
         if (rsp_tvalid && rsp_tready) begin
            seen.egress             = rsp_tdata[EGRESS_W-1:0];
            seen.out_source_l4_port = rsp_tdata[EGRESS_W +: PORT_W];
            seen.out_dest_l4_port   = rsp_tdata[EGRESS_W + PORT_W +: PORT_W];
            seen.last_copy          = rsp_tlast;
            if (copies_expected.size() == 0) begin
               $error("unexpected copy: egress %0d sport %0d dport %0d last %0d",
                      seen.egress, seen.out_source_l4_port, seen.out_dest_l4_port,
                      seen.last_copy);
               mismatches++;
            end else begin
               want = copies_expected.pop_front();
               copies_checked++;
               if (seen.egress !== want.egress) begin
                  $error("egress: expected %0d, got %0d", want.egress, seen.egress);
                  mismatches++;
               end
               if (seen.out_source_l4_port !== want.out_source_l4_port) begin
                  $error("out_source_l4_port: expected %0d, got %0d",
                         want.out_source_l4_port, seen.out_source_l4_port);
                  mismatches++;
               end
               if (seen.out_dest_l4_port !== want.out_dest_l4_port) begin
                  $error("out_dest_l4_port: expected %0d, got %0d",
                         want.out_dest_l4_port, seen.out_dest_l4_port);
                  mismatches++;
               end
               if (seen.last_copy !== want.last_copy) begin
                  $error("last_copy: expected %0d, got %0d", want.last_copy, seen.last_copy);
                  mismatches++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wen) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      unique case (idx)
         CSR_SUBNET_ADDR:     cfg_subnet_addr = val[ADDR_W-1:0];
         CSR_SUBNET_MASK:     cfg_subnet_mask = val[ADDR_W-1:0];
         CSR_INTERNAL_EGRESS: cfg_internal    = val[EGRESS_W-1:0];
         CSR_EXTERNAL_EGRESS: cfg_external    = val[EGRESS_W-1:0];
         CSR_COPY_COUNT:      cfg_copy_count  = val[COUNT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_setup(input logic [ADDR_W-1:0] addr, input logic [ADDR_W-1:0] mask,
                              input logic [EGRESS_W-1:0] int_eg,
                              input logic [EGRESS_W-1:0] ext_eg,
                              input logic [COUNT_W-1:0] count);
      csr_write(CSR_SUBNET_ADDR, addr);
      csr_write(CSR_SUBNET_MASK, mask);
      csr_write(CSR_INTERNAL_EGRESS, 32'(int_eg));
      csr_write(CSR_EXTERNAL_EGRESS, 32'(ext_eg));
      csr_write(CSR_COPY_COUNT, 32'(count));
      @(posedge clock);
      csr_wen <= 1'b0;
      setups_applied++;
   endtask

   task automatic queue_header(input logic ipv4, input logic [KIND_W-1:0] kind,
                               input logic [ADDR_W-1:0] addr,
                               input logic [PORT_W-1:0] sport,
                               input logic [PORT_W-1:0] dport);
      req_item_type hdr;
      hdr.is_ipv4        = ipv4;
      hdr.l4_kind        = kind;
      hdr.source_address = addr;
      hdr.source_l4_port = sport;
      hdr.dest_l4_port   = dport;
      pending_headers.push_back(hdr);
      queued_headers++;
   endtask

   function automatic logic [PORT_W-1:0] random_port();
      int pick;
      pick = $urandom_range(0, 11);
      if (pick < 2) begin
         return PORT_W'($urandom_range(65535 - 70, 65535));
      end else if (pick == 2) begin
         return '0;
      end
      return PORT_W'($urandom);
   endfunction

   task automatic queue_random_header();
      logic              ipv4;
      logic [KIND_W-1:0] kind;
      logic [ADDR_W-1:0] addr;
      int                pick;
      ipv4 = ($urandom_range(0, 9) != 0);
      pick = $urandom_range(0, 9);
      kind = (pick < 4) ? L4_UDP : (pick < 8) ? L4_TCP : (pick == 8) ? L4_OTHER : L4_RESERVED;
      if ($urandom_range(0, 1) == 1) begin
         addr = (cfg_subnet_addr & cfg_subnet_mask) | ($urandom & ~cfg_subnet_mask);
      end else begin
         addr = $urandom;
      end
      queue_header(ipv4, kind, addr, random_port(), random_port());
   endtask

   task automatic wait_drain();
      while (accepted_headers != queued_headers || copies_expected.size() != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      logic [ADDR_W-1:0]  mask;
      logic [COUNT_W-1:0] count;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: mask 0 puts every IPv4 source inside the subnet
      queue_header(1'b1, L4_UDP, 32'h0000_0000, 16'hFFFF, 16'h0000);
      queue_header(1'b1, L4_TCP, 32'hFFFF_FFFF, 16'h0000, 16'hFFFF);
      queue_header(1'b0, L4_UDP, 32'h1234_5678, 16'd100, 16'd200);
      queue_header(1'b1, L4_OTHER, 32'h8000_0001, 16'd7, 16'd9);
      queue_header(1'b1, L4_RESERVED, 32'h0F0F_0F0F, 16'd11, 16'd13);
      queue_header(1'b0, L4_OTHER, 32'h0000_0000, 16'hFFFF, 16'hFFFF);
      queue_header(1'b0, L4_TCP, 32'hFFFF_FFFF, 16'h0000, 16'h0000);
      queue_header(1'b1, L4_UDP, 32'hA5A5_A5A5, 16'hFFFE, 16'hFFFE);
      wait_drain();

      for (int idx = CSR_SPARE_LO; idx <= CSR_SPARE_HI; idx++) begin
         csr_write(CSR_INDEX_W'(idx), 32'hFFFF_FFFF);
      end
      apply_setup(32'h0A00_0000, 32'hFF00_0000, 8'd0, 8'd255, 7'(MAX_COPIES));
      queue_header(1'b1, L4_UDP, 32'h0A12_3456, 16'd65500, 16'd7);
      queue_header(1'b1, L4_TCP, 32'h0B00_0001, 16'd3, 16'hFFFF);
      queue_header(1'b1, L4_OTHER, 32'h0A00_0000, 16'd5, 16'd6);
      wait_drain();

      // zero copy count behaves as one
      apply_setup(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255, 8'd0, 7'd0);
      queue_header(1'b1, L4_UDP, 32'hFFFF_FFFF, 16'd1000, 16'd2000);
      queue_header(1'b1, L4_TCP, 32'hFFFF_FFFE, 16'd1000, 16'd2000);
      queue_header(1'b1, L4_UDP, 32'h0000_0000, 16'hFFFF, 16'hFFFF);
      queue_header(1'b0, L4_UDP, 32'hFFFF_FFFF, 16'd1, 16'd2);
      wait_drain();

      // copy count above the limit saturates
      apply_setup(32'h0000_0000, 32'h0000_0000, 8'd77, 8'd88, {COUNT_W{1'b1}});
      queue_header(1'b1, L4_TCP, 32'h5A5A_5A5A, 16'hFFF0, 16'd42);
      queue_header(1'b0, L4_OTHER, 32'hC0A8_0001, 16'd42, 16'hFFF0);
      wait_drain();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if ($urandom_range(0, 3) == 0) begin
            mask = $urandom;
         end else begin
            mask = 32'hFFFF_FFFF << (32 - $urandom_range(0, 32));
         end
         count = ($urandom_range(0, 4) == 0) ? COUNT_W'($urandom_range(5, 12))
                                             : COUNT_W'($urandom_range(1, 4));
         apply_setup($urandom, mask, EGRESS_W'($urandom), EGRESS_W'($urandom), count);
         if (phase == 2) begin
            stall_request <= 1'b1;
         end
         if (phase == RANDOM_PHASES - 1) begin
            calm <= 1'b1;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            queue_random_header();
         end
         wait_drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d packet headers over %0d register setups; %0d copies checked.",
               accepted_headers, setups_applied, copies_checked);
      if (mismatches == 0 && copies_expected.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ sim.f @@
src/ssr_pkg.sv
src/ssr_replicator.sv
src/subnet_steer_and_replicate.sv
tb/tb_subnet_steer_and_replicate.sv
